>>> hdl/scrp_pkg.sv
// Package for the stepper cosine ramp profiler: widths, reset values, codes
// and the quarter-period cosine table used by the interval multiplier.
// No dependencies.
package scrp_pkg;

    localparam int POS_W          = 10;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;
    localparam int COS_LEN        = 64;
    localparam int COS_W          = $clog2(COS_LEN);
    localparam int RAMP_STEPS_DEF = 64;

    localparam logic [15:0]      MIN_TICKS_RST     = 16'd100;
    localparam logic [15:0]      SPAN_TICKS_RST    = 16'd900;
    localparam logic [15:0]      SCALE_FACTOR_RST  = 16'd256;
    localparam logic [7:0]       SPEED_FACTOR_RST  = 8'd1;
    localparam logic [POS_W-1:0] LOWER_LIMIT_RST   = 10'd0;
    localparam logic [POS_W-1:0] UPPER_LIMIT_RST   = 10'd533;
    localparam logic [POS_W-1:0] HOME_POSITION_RST = 10'd267;

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_CRUISE = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_DECEL  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_MIN_TICKS     = 3'd0,
        REG_SPAN_TICKS    = 3'd1,
        REG_SCALE_FACTOR  = 3'd2,
        REG_SPEED_FACTOR  = 3'd3,
        REG_LOWER_LIMIT   = 3'd4,
        REG_UPPER_LIMIT   = 3'd5,
        REG_HOME_POSITION = 3'd6
    } cfg_reg_t;

    function automatic logic [15:0] cos_q16(input logic [COS_W-1:0] k);
        logic [15:0] c;
        case (k)
            6'd0:  c = 16'd65516;
            6'd1:  c = 16'd65457;
            6'd2:  c = 16'd65359;
            6'd3:  c = 16'd65221;
            6'd4:  c = 16'd65044;
            6'd5:  c = 16'd64828;
            6'd6:  c = 16'd64573;
            6'd7:  c = 16'd64278;
            6'd8:  c = 16'd63943;
            6'd9:  c = 16'd63570;
            6'd10: c = 16'd63164;
            6'd11: c = 16'd62711;
            6'd12: c = 16'd62226;
            6'd13: c = 16'd61702;
            6'd14: c = 16'd61145;
            6'd15: c = 16'd60549;
            6'd16: c = 16'd59913;
            6'd17: c = 16'd59245;
            6'd18: c = 16'd58537;
            6'd19: c = 16'd57796;
            6'd20: c = 16'd57023;
            6'd21: c = 16'd56210;
            6'd22: c = 16'd55365;
            6'd23: c = 16'd54493;
            6'd24: c = 16'd53582;
            6'd25: c = 16'd52639;
            6'd26: c = 16'd51662;
            6'd27: c = 16'd50659;
            6'd28: c = 16'd49624;
            6'd29: c = 16'd48556;
            6'd30: c = 16'd47461;
            6'd31: c = 16'd46341;
            6'd32: c = 16'd45187;
            6'd33: c = 16'd44007;
            6'd34: c = 16'd42808;
            6'd35: c = 16'd41576;
            6'd36: c = 16'd40318;
            6'd37: c = 16'd39040;
            6'd38: c = 16'd37736;
            6'd39: c = 16'd36412;
            6'd40: c = 16'd35062;
            6'd41: c = 16'd33692;
            6'd42: c = 16'd32303;
            6'd43: c = 16'd30894;
            6'd44: c = 16'd29465;
            6'd45: c = 16'd28017;
            6'd46: c = 16'd26555;
            6'd47: c = 16'd25081;
            6'd48: c = 16'd23586;
            6'd49: c = 16'd22079;
            6'd50: c = 16'd20559;
            6'd51: c = 16'd19025;
            6'd52: c = 16'd17478;
            6'd53: c = 16'd15925;
            6'd54: c = 16'd14359;
            6'd55: c = 16'd12786;
            6'd56: c = 16'd11207;
            6'd57: c = 16'd9614;
            6'd58: c = 16'd8022;
            6'd59: c = 16'd6423;
            6'd60: c = 16'd4823;
            6'd61: c = 16'd3218;
            6'd62: c = 16'd1606;
            6'd63: c = 16'd0;
            default: c = 16'd0;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/stepper_cosine_ramp_profiler_core.sv
// Top level of the stepper cosine ramp profiler: APB register bank, move and
// tick control, and a shared bit-serial multiplier for the step interval.
// Depends on scrp_pkg.

// One item is taken at a time. An item that needs no new step interval (a
// refused or busy move, an idle tick, a cruise tick or the last step) goes
// straight to the result state; its result is loaded into the output register
// once that register is free, and the next item can be accepted from then on. An
// accepted move or a ramp tick loads a new interval, which the shift-add
// multiplier builds one multiplier bit per cycle in three passes (scale times
// speed, span times cosine, then the final product) before the result state. A
// new item is accepted while the previous result still waits in the output
// register. There is no clearing pass after reset.
module stepper_cosine_ramp_profiler_core
    import scrp_pkg::*;
#(
    parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [POS_W-1:0]  s_target_position,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_step_pulse,
    output logic              m_dir_anticlockwise,
    output logic [15:0]       m_interval,
    output logic [POS_W-1:0]  m_position,
    output logic              m_moving,
    output logic [1:0]        m_ramp_phase,
    output logic [1:0]        m_status
);

    localparam int RAMP_W      = $clog2(2 * RAMP_STEPS + 1);
    localparam int CMP_W       = ((POS_W > RAMP_W) ? POS_W : RAMP_W) + 1;
    localparam logic [CMP_W-1:0] RAMP_C  = CMP_W'(RAMP_STEPS);
    localparam logic [CMP_W-1:0] RAMP2_C = CMP_W'(2 * RAMP_STEPS);

    localparam int MUL_MW      = 33;
    localparam int MUL_HW      = MUL_MW + 1;
    localparam int MUL_QW      = 24;
    localparam int MUL_PW      = MUL_HW + MUL_QW;
    localparam int FACT_STEPS  = 8;
    localparam int PROD_STEPS  = 16;
    localparam int SCALE_STEPS = 24;
    localparam int CNT_W       = $clog2(SCALE_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FACT,
        S_PROD,
        S_SCALE,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;

    logic [15:0]         min_ticks_reg, min_ticks_next;
    logic [15:0]         span_ticks_reg, span_ticks_next;
    logic [15:0]         scale_factor_reg, scale_factor_next;
    logic [7:0]          speed_factor_reg, speed_factor_next;
    logic [POS_W-1:0]    lower_limit_reg, lower_limit_next;
    logic [POS_W-1:0]    upper_limit_reg, upper_limit_next;
    logic [POS_W-1:0]    home_position_reg, home_position_next;

    logic [POS_W-1:0]    position_reg, position_next;
    logic                direction_reg, direction_next;
    logic [POS_W-1:0]    steps_done_reg, steps_done_next;
    logic [POS_W-1:0]    steps_total_reg, steps_total_next;
    logic [15:0]         interval_reg, interval_next;
    phase_t              phase_reg, phase_next;

    logic                pulse_reg, pulse_next;
    status_t             status_reg, status_next;
    logic [COS_W-1:0]    k_reg, k_next;

    logic [MUL_MW-1:0]   mul_m_reg, mul_m_next;
    logic [MUL_PW-1:0]   mul_p_reg, mul_p_next;
    logic [MUL_QW-1:0]   fact_reg, fact_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                m_valid_reg, m_valid_next;
    logic                out_pulse_reg, out_pulse_next;
    logic                out_dir_reg, out_dir_next;
    logic [15:0]         out_interval_reg, out_interval_next;
    logic [POS_W-1:0]    out_position_reg, out_position_next;
    logic                out_moving_reg, out_moving_next;
    logic [1:0]          out_phase_reg, out_phase_next;
    logic [1:0]          out_status_reg, out_status_next;

    logic                accept;
    logic                cfg_write;
    logic [2:0]          cfg_index;
    logic [MUL_HW-1:0]   mul_hi;
    logic [MUL_HW-1:0]   mul_sum;
    logic [MUL_PW-1:0]   mul_step;
    logic [MUL_HW-1:0]   mul_res;

    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[APB_AW-1:2];
    assign pready    = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    assign mul_hi   = mul_p_reg[MUL_PW-1 -: MUL_HW];
    assign mul_sum  = mul_p_reg[0] ? (mul_hi + MUL_HW'(mul_m_reg)) : mul_hi;
    assign mul_step = {1'b0, mul_sum, mul_p_reg[MUL_QW-1:1]};
    assign mul_res  = mul_step[MUL_PW-1 -: MUL_HW];

    always_comb begin
        prdata = '0;
        case (cfg_index)
            REG_MIN_TICKS:     prdata = APB_DW'(min_ticks_reg);
            REG_SPAN_TICKS:    prdata = APB_DW'(span_ticks_reg);
            REG_SCALE_FACTOR:  prdata = APB_DW'(scale_factor_reg);
            REG_SPEED_FACTOR:  prdata = APB_DW'(speed_factor_reg);
            REG_LOWER_LIMIT:   prdata = APB_DW'(lower_limit_reg);
            REG_UPPER_LIMIT:   prdata = APB_DW'(upper_limit_reg);
            REG_HOME_POSITION: prdata = APB_DW'(home_position_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        logic [POS_W-1:0] sd;
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] k_sel;
        logic             need_mul;

        sd       = steps_done_reg + POS_W'(1);
        left     = steps_total_reg - sd;
        k_sel    = POS_W'(1);
        need_mul = 1'b0;

        state_next         = state_reg;
        min_ticks_next     = min_ticks_reg;
        span_ticks_next    = span_ticks_reg;
        scale_factor_next  = scale_factor_reg;
        speed_factor_next  = speed_factor_reg;
        lower_limit_next   = lower_limit_reg;
        upper_limit_next   = upper_limit_reg;
        home_position_next = home_position_reg;
        position_next      = position_reg;
        direction_next     = direction_reg;
        steps_done_next    = steps_done_reg;
        steps_total_next   = steps_total_reg;
        interval_next      = interval_reg;
        phase_next         = phase_reg;
        pulse_next         = pulse_reg;
        status_next        = status_reg;
        k_next             = k_reg;
        mul_m_next         = mul_m_reg;
        mul_p_next         = mul_p_reg;
        fact_next          = fact_reg;
        cnt_next           = cnt_reg;
        m_valid_next       = m_valid_reg;
        out_pulse_next     = out_pulse_reg;
        out_dir_next       = out_dir_reg;
        out_interval_next  = out_interval_reg;
        out_position_next  = out_position_reg;
        out_moving_next    = out_moving_reg;
        out_phase_next     = out_phase_reg;
        out_status_next    = out_status_reg;

        if (cfg_write) begin
            case (cfg_index)
                REG_MIN_TICKS:     min_ticks_next    = pwdata[15:0];
                REG_SPAN_TICKS:    span_ticks_next   = pwdata[15:0];
                REG_SCALE_FACTOR:  scale_factor_next = pwdata[15:0];
                REG_SPEED_FACTOR:  speed_factor_next = pwdata[7:0];
                REG_LOWER_LIMIT:   lower_limit_next  = pwdata[POS_W-1:0];
                REG_UPPER_LIMIT:   upper_limit_next  = pwdata[POS_W-1:0];
                REG_HOME_POSITION: begin
                    home_position_next = pwdata[POS_W-1:0];
                    if (steps_total_reg == '0) begin
                        position_next = pwdata[POS_W-1:0];
                    end
                end
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pulse_next  = 1'b0;
                    status_next = ST_OK;
                    if (s_command == CMD_MOVE) begin
                        if (steps_total_reg != '0) begin
                            status_next = ST_BUSY;
                        end else begin
                            if (position_reg > s_target_position) begin
                                direction_next = 1'b0;
                            end else if (position_reg < s_target_position) begin
                                direction_next = 1'b1;
                            end
                            if (s_target_position > upper_limit_reg ||
                                s_target_position < lower_limit_reg) begin
                                status_next = ST_RANGE;
                            end else begin
                                steps_total_next = (position_reg > s_target_position) ?
                                    position_reg - s_target_position :
                                    s_target_position - position_reg;
                                steps_done_next  = '0;
                                phase_next       = PH_CRUISE;
                                k_sel            = POS_W'(1);
                                need_mul         = 1'b1;
                            end
                        end
                    end else if (steps_total_reg != '0) begin
                        pulse_next      = 1'b1;
                        steps_done_next = sd;
                        position_next   = direction_reg ? position_reg + POS_W'(1) :
                                                          position_reg - POS_W'(1);
                        if (sd == steps_total_reg) begin
                            steps_done_next  = '0;
                            steps_total_next = '0;
                            phase_next       = PH_CRUISE;
                        end else if (CMP_W'(sd) <= RAMP_C || CMP_W'(left) <= RAMP_C) begin
                            if (CMP_W'(steps_total_reg) > RAMP2_C) begin
                                if (CMP_W'(sd) < RAMP_C) begin
                                    k_sel      = sd;
                                    phase_next = PH_ACCEL;
                                    need_mul   = 1'b1;
                                end else if (CMP_W'(left) < RAMP_C) begin
                                    k_sel      = left;
                                    phase_next = PH_DECEL;
                                    need_mul   = 1'b1;
                                end else begin
                                    phase_next = PH_CRUISE;
                                end
                            end else if (sd < (steps_total_reg >> 1)) begin
                                k_sel      = sd;
                                phase_next = PH_ACCEL;
                                need_mul   = 1'b1;
                            end else begin
                                k_sel      = left;
                                phase_next = PH_DECEL;
                                need_mul   = 1'b1;
                            end
                        end else begin
                            phase_next = PH_CRUISE;
                        end
                    end
                    k_next     = (k_sel > POS_W'(COS_LEN - 1)) ? COS_W'(COS_LEN - 1) :
                                                                 k_sel[COS_W-1:0];
                    mul_m_next = MUL_MW'(scale_factor_reg);
                    mul_p_next = MUL_PW'(speed_factor_reg);
                    cnt_next   = CNT_W'(FACT_STEPS - 1);
                    state_next = need_mul ? S_FACT : S_FIN;
                end
            end
            S_FACT: begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    fact_next  = mul_step[SCALE_STEPS-FACT_STEPS +: MUL_QW];
                    mul_m_next = MUL_MW'(span_ticks_reg);
                    mul_p_next = MUL_PW'(cos_q16(k_reg));
                    cnt_next   = CNT_W'(PROD_STEPS - 1);
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    mul_m_next = {1'b0, min_ticks_reg, 16'd0} +
                                 {1'b0, mul_step[SCALE_STEPS-PROD_STEPS +: 32]};
                    mul_p_next = MUL_PW'(fact_reg);
                    cnt_next   = CNT_W'(SCALE_STEPS - 1);
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    interval_next = (|mul_res[MUL_HW-1:16]) ? 16'hFFFF : mul_res[15:0];
                    state_next    = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    out_pulse_next    = pulse_reg;
                    out_dir_next      = direction_reg;
                    out_interval_next = interval_reg;
                    out_position_next = position_reg;
                    out_moving_next   = (steps_total_reg != '0);
                    out_phase_next    = phase_reg;
                    out_status_next   = status_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        k_reg            <= k_next;
        mul_m_reg        <= mul_m_next;
        mul_p_reg        <= mul_p_next;
        fact_reg         <= fact_next;
        cnt_reg          <= cnt_next;
        pulse_reg        <= pulse_next;
        status_reg       <= status_next;
        out_pulse_reg    <= out_pulse_next;
        out_dir_reg      <= out_dir_next;
        out_interval_reg <= out_interval_next;
        out_position_reg <= out_position_next;
        out_moving_reg   <= out_moving_next;
        out_phase_reg    <= out_phase_next;
        out_status_reg   <= out_status_next;
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            min_ticks_reg     <= MIN_TICKS_RST;
            span_ticks_reg    <= SPAN_TICKS_RST;
            scale_factor_reg  <= SCALE_FACTOR_RST;
            speed_factor_reg  <= SPEED_FACTOR_RST;
            lower_limit_reg   <= LOWER_LIMIT_RST;
            upper_limit_reg   <= UPPER_LIMIT_RST;
            home_position_reg <= HOME_POSITION_RST;
            position_reg      <= HOME_POSITION_RST;
            direction_reg     <= 1'b0;
            steps_done_reg    <= '0;
            steps_total_reg   <= '0;
            interval_reg      <= '0;
            phase_reg         <= PH_CRUISE;
        end else begin
            state_reg         <= state_next;
            m_valid_reg       <= m_valid_next;
            min_ticks_reg     <= min_ticks_next;
            span_ticks_reg    <= span_ticks_next;
            scale_factor_reg  <= scale_factor_next;
            speed_factor_reg  <= speed_factor_next;
            lower_limit_reg   <= lower_limit_next;
            upper_limit_reg   <= upper_limit_next;
            home_position_reg <= home_position_next;
            position_reg      <= position_next;
            direction_reg     <= direction_next;
            steps_done_reg    <= steps_done_next;
            steps_total_reg   <= steps_total_next;
            interval_reg      <= interval_next;
            phase_reg         <= phase_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_step_pulse        = out_pulse_reg;
    assign m_dir_anticlockwise = out_dir_reg;
    assign m_interval          = out_interval_reg;
    assign m_position          = out_position_reg;
    assign m_moving            = out_moving_reg;
    assign m_ramp_phase        = out_phase_reg;
    assign m_status            = out_status_reg;

    a_done_below_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (steps_total_reg != '0) |-> (steps_done_reg < steps_total_reg))
        else $error("Steps done has reached the step total during a move.");

    a_idle_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (steps_total_reg == '0) |-> (steps_done_reg == '0))
        else $error("Step count is not clear while the axis is idle.");

    a_tick_moves_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_TICK && steps_total_reg != '0)
        |=> (position_reg != $past(position_reg)))
        else $error("A step tick during a move left the position unchanged.");

    a_busy_move_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_MOVE && steps_total_reg != '0)
        |=> (steps_total_reg == $past(steps_total_reg) &&
             position_reg == $past(position_reg)))
        else $error("A refused move during a move altered the axis state.");

endmodule
